// ===== hw/rtl/cdlm_pkg.sv =====
// Shared types, constants and helper functions of the cyclic deadline latency monitor.
`default_nettype none

package cdlm_pkg;

   // Time values are taken modulo 2^TIME_BITS
   localparam int TIME_BITS     = 48;
   localparam int HIST_BINS_DEF = 1024;
   localparam int CNT_BITS      = $clog2(TIME_BITS + 1);
   localparam int PADDR_BITS    = 4;
   localparam int IDX_BITS      = 10;

   localparam logic [31:0] PERIOD_RESET = 32'd1000;

   // Error code bit positions
   localparam int ERR_LAT  = 0;
   localparam int ERR_EXEC = 1;

   // Statistic selectors for the read-statistic action
   localparam logic [IDX_BITS-1:0] STAT_LAT_SUM   = 10'd0;
   localparam logic [IDX_BITS-1:0] STAT_LAT_COUNT = 10'd1;
   localparam logic [IDX_BITS-1:0] STAT_EXE_SUM   = 10'd2;
   localparam logic [IDX_BITS-1:0] STAT_EXE_COUNT = 10'd3;
   localparam logic [IDX_BITS-1:0] STAT_OVERFLOW  = 10'd4;

   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_CYCLE = 2'd1,
      ACT_BIN   = 2'd2,
      ACT_STAT  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_PERIOD    = 2'd0,
      REG_MEASURE   = 2'd1,
      REG_APERIODIC = 2'd2,
      REG_RUN_MORE  = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_EXEC,
      ST_ADV,
      ST_DIV,
      ST_LAT,
      ST_HWR,
      ST_BIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] period;
      logic        measure;
      logic        aperiodic;
      logic        run_more;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic clr_wr;
      logic start_set;
      logic exec_upd;
      logic dl_aper;
      logic dl_nomiss;
      logic div_start;
      logic miss_upd;
      logic lat_upd;
      logic hist_wr;
      logic bin_rd;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic aperiodic;
      logic p_zero;
      logic end_gt_nd;
      logic div_done;
      logic lat_hist;
      logic clr_last;
      logic out_free;
   } sts_type;

   // Saturate a time difference to 32 bits
   function automatic logic [31:0] clip_time(input logic [TIME_BITS:0] v);
      logic [31:0] r;
      r = (|v[TIME_BITS:32]) ? 32'hFFFF_FFFF : v[31:0];
      return r;
   endfunction

   // Saturating increment of a 32-bit count
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      logic [31:0] r;
      r = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cyclic_deadline_latency_monitor.sv =====
// Top level of the cyclic deadline latency monitor: register file, sequencer, datapath.
//
//   Channel   Direction  Handshake               Carries
//   req_*     in         req_valid / req_stall   action, end and wake times, run-more, index
//   rsp_*     out        rsp_valid / rsp_stall   cycle values, statistics, error, read value
//   APB       in/out     psel, penable, pready   period, measure, aperiodic, run-more enable
//
// After reset the histogram is swept to zero, one bin a cycle; no request is taken
// meanwhile, register writes are. A statistic read goes straight to the result load;
// a start, a bin read or a skipped sleep passes through its own step first. A periodic
// cycle item steps through execution time, deadline advance, the bit-serial divider when
// the deadline is missed, latency and histogram increment; aperiodic or zero period skips
// the advance, and the increment is skipped when no bin is counted. A held result
// (rsp_stall high) blocks only the next result load; the block takes the next request meanwhile.
`default_nettype none

module cyclic_deadline_latency_monitor #(
   parameter int HIST_BINS = cdlm_pkg::HIST_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [cdlm_pkg::TIME_BITS-1:0]      req_end_time_us,
   input  logic [cdlm_pkg::TIME_BITS-1:0]      req_wake_time_us,
   input  logic                                req_task_more,
   input  logic [cdlm_pkg::IDX_BITS-1:0]       req_read_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_exec_time_us,
   output logic [31:0]                         rsp_latency_us,
   output logic [31:0]                         rsp_missed_now,
   output logic [31:0]                         rsp_missed_total,
   output logic [31:0]                         rsp_max_single_missed,
   output logic [31:0]                         rsp_latency_min,
   output logic [31:0]                         rsp_latency_max,
   output logic [31:0]                         rsp_exec_min,
   output logic [31:0]                         rsp_exec_max,
   output logic [1:0]                          rsp_error_code,
   output logic [63:0]                         rsp_read_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cdlm_pkg::PADDR_BITS-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   cdlm_pkg::cfg_type cfg;
   cdlm_pkg::cmd_type cmd;
   cdlm_pkg::sts_type sts;

   cdlm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cdlm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdlm_dpath #(
      .HIST_BINS (HIST_BINS)
   ) u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_action            (req_action),
      .req_end_time_us       (req_end_time_us),
      .req_wake_time_us      (req_wake_time_us),
      .req_task_more         (req_task_more),
      .req_read_index        (req_read_index),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_exec_time_us      (rsp_exec_time_us),
      .rsp_latency_us        (rsp_latency_us),
      .rsp_missed_now        (rsp_missed_now),
      .rsp_missed_total      (rsp_missed_total),
      .rsp_max_single_missed (rsp_max_single_missed),
      .rsp_latency_min       (rsp_latency_min),
      .rsp_latency_max       (rsp_latency_max),
      .rsp_exec_min          (rsp_exec_min),
      .rsp_exec_max          (rsp_exec_max),
      .rsp_error_code        (rsp_error_code),
      .rsp_read_value        (rsp_read_value)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/cdlm_csr.sv =====
// APB-style configuration register file of the latency monitor.
`default_nettype none

module cdlm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cdlm_pkg::PADDR_BITS-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output cdlm_pkg::cfg_type                cfg
);

   cdlm_pkg::cfg_type       cfg_ff;
   cdlm_pkg::reg_index_type reg_sel;
   logic                    wr_en;

   assign reg_sel = cdlm_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Write registers on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period    <= cdlm_pkg::PERIOD_RESET;
         cfg_ff.measure   <= 1'b1;
         cfg_ff.aperiodic <= 1'b0;
         cfg_ff.run_more  <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_sel)
            cdlm_pkg::REG_PERIOD:    cfg_ff.period    <= pwdata;
            cdlm_pkg::REG_MEASURE:   cfg_ff.measure   <= pwdata[0];
            cdlm_pkg::REG_APERIODIC: cfg_ff.aperiodic <= pwdata[0];
            cdlm_pkg::REG_RUN_MORE:  cfg_ff.run_more  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_sel)
         cdlm_pkg::REG_PERIOD:    prdata = cfg_ff.period;
         cdlm_pkg::REG_MEASURE:   prdata = {31'd0, cfg_ff.measure};
         cdlm_pkg::REG_APERIODIC: prdata = {31'd0, cfg_ff.aperiodic};
         cdlm_pkg::REG_RUN_MORE:  prdata = {31'd0, cfg_ff.run_more};
         default:                 prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cdlm_div.sv =====
// Radix-2 restoring divider for the missed-period count, one quotient bit a cycle.
`default_nettype none

module cdlm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [cdlm_pkg::TIME_BITS-1:0]   dividend,
   input  logic [31:0]                      divisor,
   output logic                             busy,
   output logic                             done,
   output logic [cdlm_pkg::TIME_BITS-1:0]   quot,
   output logic [31:0]                      rem
);

   localparam int TB = cdlm_pkg::TIME_BITS;
   localparam int CB = cdlm_pkg::CNT_BITS;

   logic          busy_ff;
   logic          done_ff;
   logic [CB-1:0] cnt_ff;
   logic [TB-1:0] quot_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   dsr_ff;
   logic [32:0]   trial;
   logic [32:0]   diff;
   logic          fits;
   logic          below;

   assign trial = {rem_ff, quot_ff[TB-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign below = dividend < TB'(divisor);

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

   // Sequence control: a dividend below the divisor finishes at once
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= ~below;
         done_ff <= below;
         cnt_ff  <= CB'(TB);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Shift dividend bits out, quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         dsr_ff <= divisor;
         if (below) begin
            quot_ff <= '0;
            rem_ff  <= dividend[31:0];
         end else begin
            quot_ff <= dividend;
            rem_ff  <= '0;
         end
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[31:0] : trial[31:0];
         quot_ff <= {quot_ff[TB-2:0], fits};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cdlm_ctrl.sv =====
// Sequencer of the latency monitor: steps one item through the datapath.
`default_nettype none

module cdlm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_action,
   output logic               req_stall,
   input  cdlm_pkg::sts_type  sts,
   output cdlm_pkg::cmd_type  cmd
);

   cdlm_pkg::state_type state_ff;
   cdlm_pkg::state_type state_in;

   // State register; reset starts the histogram clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdlm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cdlm_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = cdlm_pkg::ST_IDLE;
         end
         cdlm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (cdlm_pkg::action_type'(req_action))
                  cdlm_pkg::ACT_START: state_in = cdlm_pkg::ST_START;
                  cdlm_pkg::ACT_CYCLE: state_in = cdlm_pkg::ST_EXEC;
                  cdlm_pkg::ACT_BIN:   state_in = cdlm_pkg::ST_BIN;
                  cdlm_pkg::ACT_STAT:  state_in = cdlm_pkg::ST_DONE;
                  default:             state_in = cdlm_pkg::ST_DONE;
               endcase
            end
         end
         cdlm_pkg::ST_START: begin
            cmd.start_set = 1'b1;
            state_in      = cdlm_pkg::ST_DONE;
         end
         cdlm_pkg::ST_EXEC: begin
            cmd.exec_upd = 1'b1;
            if (sts.skip) begin
               state_in = cdlm_pkg::ST_DONE;
            end else if (sts.aperiodic) begin
               cmd.dl_aper = 1'b1;
               state_in    = cdlm_pkg::ST_LAT;
            end else if (sts.p_zero) begin
               state_in = cdlm_pkg::ST_LAT;
            end else begin
               state_in = cdlm_pkg::ST_ADV;
            end
         end
         cdlm_pkg::ST_ADV: begin
            if (sts.end_gt_nd) begin
               cmd.div_start = 1'b1;
               state_in      = cdlm_pkg::ST_DIV;
            end else begin
               cmd.dl_nomiss = 1'b1;
               state_in      = cdlm_pkg::ST_LAT;
            end
         end
         cdlm_pkg::ST_DIV: begin
            if (sts.div_done) begin
               cmd.miss_upd = 1'b1;
               state_in     = cdlm_pkg::ST_LAT;
            end
         end
         cdlm_pkg::ST_LAT: begin
            cmd.lat_upd = 1'b1;
            state_in    = sts.lat_hist ? cdlm_pkg::ST_HWR : cdlm_pkg::ST_DONE;
         end
         cdlm_pkg::ST_HWR: begin
            cmd.hist_wr = 1'b1;
            state_in    = cdlm_pkg::ST_DONE;
         end
         cdlm_pkg::ST_BIN: begin
            cmd.bin_rd = 1'b1;
            state_in   = cdlm_pkg::ST_DONE;
         end
         cdlm_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = cdlm_pkg::ST_IDLE;
            end
         end
         default: state_in = cdlm_pkg::ST_IDLE;
      endcase
   end

   // An accepted item always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != cdlm_pkg::ST_IDLE))
      else $error("accepted item did not start work");

   // Never load the output register over a result still held
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over a stalled result");

   // Wait in the divide step until the quotient is ready
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdlm_pkg::ST_DIV && !sts.div_done) |=> (state_ff == cdlm_pkg::ST_DIV))
      else $error("left divide step early");

endmodule

`default_nettype wire

// ===== hw/rtl/cdlm_dpath.sv =====
// Datapath of the latency monitor: timing state, statistics, histogram memory, result register.
`default_nettype none

module cdlm_dpath #(
   parameter int HIST_BINS = cdlm_pkg::HIST_BINS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdlm_pkg::cfg_type                   cfg,
   input  cdlm_pkg::cmd_type                   cmd,
   output cdlm_pkg::sts_type                   sts,
   input  logic [1:0]                          req_action,
   input  logic [cdlm_pkg::TIME_BITS-1:0]      req_end_time_us,
   input  logic [cdlm_pkg::TIME_BITS-1:0]      req_wake_time_us,
   input  logic                                req_task_more,
   input  logic [cdlm_pkg::IDX_BITS-1:0]       req_read_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_exec_time_us,
   output logic [31:0]                         rsp_latency_us,
   output logic [31:0]                         rsp_missed_now,
   output logic [31:0]                         rsp_missed_total,
   output logic [31:0]                         rsp_max_single_missed,
   output logic [31:0]                         rsp_latency_min,
   output logic [31:0]                         rsp_latency_max,
   output logic [31:0]                         rsp_exec_min,
   output logic [31:0]                         rsp_exec_max,
   output logic [1:0]                          rsp_error_code,
   output logic [63:0]                         rsp_read_value
);

   localparam int TB      = cdlm_pkg::TIME_BITS;
   localparam int HIST_AW = $clog2(HIST_BINS);

   // Captured request
   logic [1:0]                      action_ff;
   logic [TB-1:0]                   end_ff;
   logic [TB-1:0]                   wake_ff;
   logic                            more_ff;
   logic [cdlm_pkg::IDX_BITS-1:0]   idx_ff;

   // Architectural state
   logic [TB-1:0] deadline_ff;
   logic [TB-1:0] last_wake_ff;
   logic [31:0]   miss_total_ff;
   logic [31:0]   miss_max_ff;
   logic [31:0]   lat_min_ff;
   logic [31:0]   lat_max_ff;
   logic [63:0]   lat_sum_ff;
   logic [31:0]   lat_cnt_ff;
   logic [31:0]   exe_min_ff;
   logic [31:0]   exe_max_ff;
   logic [63:0]   exe_sum_ff;
   logic [31:0]   exe_cnt_ff;
   logic [31:0]   hist_ovf_ff;

   // Per-item working registers
   logic [TB-1:0]      nd_ff;
   logic [31:0]        ex_ff;
   logic [31:0]        lat_ff;
   logic [31:0]        mnow_ff;
   logic [1:0]         err_ff;
   logic [HIST_AW-1:0] hadr_ff;
   logic [HIST_AW-1:0] clr_ff;

   // Histogram memory
   logic [31:0]        hist_mem [HIST_BINS];
   logic [31:0]        rdata_ff;
   logic               mem_we;
   logic [HIST_AW-1:0] mem_wa;
   logic [31:0]        mem_wd;
   logic               mem_re;
   logic [HIST_AW-1:0] mem_ra;

   // Combinational arithmetic
   logic [TB-1:0] exe_diff;
   logic          exe_neg;
   logic [31:0]   exe_val;
   logic [TB-1:0] nd_in;
   logic [TB-1:0] aper_dl;
   logic [TB-1:0] miss_x;
   logic [TB-1:0] lat_diff;
   logic          lat_neg;
   logic [31:0]   lat_val;
   logic          lat_in_hist;
   logic [TB:0]   quot_p1;
   logic [31:0]   mnow_in;
   logic [31:0]   pad_us;
   logic [TB-1:0] miss_dl;
   logic [32:0]   miss_sum;
   logic [31:0]   miss_total_in;
   logic          idx_in_hist;
   logic [63:0]   rv_in;

   // Divider
   logic          div_busy;
   logic          div_done;
   logic [TB-1:0] div_quot;
   logic [31:0]   div_rem;

   // Output register
   logic          rsp_valid_ff;
   logic [31:0]   out_ex_ff;
   logic [31:0]   out_lat_ff;
   logic [31:0]   out_mnow_ff;
   logic [31:0]   out_mtot_ff;
   logic [31:0]   out_mmax_ff;
   logic [31:0]   out_lmin_ff;
   logic [31:0]   out_lmax_ff;
   logic [31:0]   out_emin_ff;
   logic [31:0]   out_emax_ff;
   logic [1:0]    out_err_ff;
   logic [63:0]   out_rv_ff;

   cdlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (miss_x),
      .divisor  (cfg.period),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Execution time, deadline step and latency
   always_comb begin
      exe_diff      = end_ff - last_wake_ff;
      exe_neg       = end_ff < last_wake_ff;
      exe_val       = cdlm_pkg::clip_time({1'b0, exe_diff});
      nd_in         = deadline_ff + TB'(cfg.period);
      aper_dl       = end_ff + TB'(cfg.period);
      miss_x        = end_ff - nd_ff - TB'(1);
      lat_diff      = wake_ff - deadline_ff;
      lat_neg       = wake_ff < deadline_ff;
      lat_val       = cdlm_pkg::clip_time({1'b0, lat_diff});
      lat_in_hist   = lat_val < 32'(HIST_BINS);
      // Missed k periods: new deadline is end + period - 1 - remainder
      quot_p1       = {1'b0, div_quot} + (TB+1)'(1);
      mnow_in       = cdlm_pkg::clip_time(quot_p1);
      pad_us        = cfg.period - 32'd1 - div_rem;
      miss_dl       = end_ff + TB'(pad_us);
      miss_sum      = {1'b0, miss_total_ff} + {1'b0, mnow_in};
      miss_total_in = miss_sum[32] ? 32'hFFFF_FFFF : miss_sum[31:0];
      idx_in_hist   = {22'd0, idx_ff} < 32'(HIST_BINS);
   end

   // Capture the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         end_ff    <= req_end_time_us;
         wake_ff   <= req_wake_time_us;
         more_ff   <= req_task_more;
         idx_ff    <= req_read_index;
      end
   end

   // Timing state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff   <= '0;
         last_wake_ff  <= '0;
         miss_total_ff <= '0;
         miss_max_ff   <= '0;
         lat_min_ff    <= '1;
         lat_max_ff    <= '0;
         lat_sum_ff    <= '0;
         lat_cnt_ff    <= '0;
         exe_min_ff    <= '1;
         exe_max_ff    <= '0;
         exe_sum_ff    <= '0;
         exe_cnt_ff    <= '0;
         hist_ovf_ff   <= '0;
      end else begin
         if (cmd.start_set) begin
            deadline_ff  <= wake_ff;
            last_wake_ff <= wake_ff;
         end
         if (cmd.exec_upd && cfg.measure && !exe_neg) begin
            if (exe_val > exe_max_ff) exe_max_ff <= exe_val;
            if (exe_val < exe_min_ff) exe_min_ff <= exe_val;
            exe_sum_ff <= exe_sum_ff + {32'd0, exe_val};
            exe_cnt_ff <= cdlm_pkg::sat_inc(exe_cnt_ff);
         end
         if (cmd.dl_aper) deadline_ff <= aper_dl;
         if (cmd.dl_nomiss) deadline_ff <= nd_ff;
         if (cmd.miss_upd) begin
            deadline_ff   <= miss_dl;
            miss_total_ff <= miss_total_in;
            if (mnow_in > miss_max_ff) miss_max_ff <= mnow_in;
         end
         if (cmd.lat_upd) begin
            last_wake_ff <= wake_ff;
            if (cfg.measure && !lat_neg) begin
               if (lat_val > lat_max_ff) lat_max_ff <= lat_val;
               if (lat_val < lat_min_ff) lat_min_ff <= lat_val;
               lat_sum_ff <= lat_sum_ff + {32'd0, lat_val};
               lat_cnt_ff <= cdlm_pkg::sat_inc(lat_cnt_ff);
               if (!lat_in_hist) hist_ovf_ff <= cdlm_pkg::sat_inc(hist_ovf_ff);
            end
         end
      end
   end

   // Per-item values: cleared on transfer, filled as the item advances
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ex_ff   <= '0;
         lat_ff  <= '0;
         mnow_ff <= '0;
         err_ff  <= '0;
      end
      if (cmd.exec_upd) begin
         nd_ff <= nd_in;
         if (cfg.measure) begin
            if (exe_neg) err_ff[cdlm_pkg::ERR_EXEC] <= 1'b1;
            else         ex_ff <= exe_val;
         end
      end
      if (cmd.miss_upd) mnow_ff <= mnow_in;
      if (cmd.lat_upd && cfg.measure) begin
         hadr_ff <= HIST_AW'(lat_val);
         if (lat_neg) err_ff[cdlm_pkg::ERR_LAT] <= 1'b1;
         else         lat_ff <= lat_val;
      end
   end

   // Clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + HIST_AW'(1);
      end
   end

   // Histogram port select: clear or increment write, bin or latency read
   always_comb begin
      mem_we = cmd.clr_wr | cmd.hist_wr;
      mem_wa = cmd.clr_wr ? clr_ff : hadr_ff;
      mem_wd = cmd.clr_wr ? 32'd0 : cdlm_pkg::sat_inc(rdata_ff);
      mem_re = cmd.lat_upd | cmd.bin_rd;
      mem_ra = cmd.bin_rd ? HIST_AW'(idx_ff) : HIST_AW'(lat_val);
   end

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[mem_wa] <= mem_wd;
      if (mem_re) rdata_ff <= hist_mem[mem_ra];
   end

   // Read value for the read actions
   always_comb begin
      rv_in = 64'd0;
      case (cdlm_pkg::action_type'(action_ff))
         cdlm_pkg::ACT_BIN: begin
            if (idx_in_hist) rv_in = {32'd0, rdata_ff};
         end
         cdlm_pkg::ACT_STAT: begin
            case (idx_ff)
               cdlm_pkg::STAT_LAT_SUM:   rv_in = lat_sum_ff;
               cdlm_pkg::STAT_LAT_COUNT: rv_in = {32'd0, lat_cnt_ff};
               cdlm_pkg::STAT_EXE_SUM:   rv_in = exe_sum_ff;
               cdlm_pkg::STAT_EXE_COUNT: rv_in = {32'd0, exe_cnt_ff};
               cdlm_pkg::STAT_OVERFLOW:  rv_in = {32'd0, hist_ovf_ff};
               default:                  rv_in = 64'd0;
            endcase
         end
         default: rv_in = 64'd0;
      endcase
   end

   // Result register: hold while stalled, drop valid after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ex_ff   <= ex_ff;
         out_lat_ff  <= lat_ff;
         out_mnow_ff <= mnow_ff;
         out_mtot_ff <= miss_total_ff;
         out_mmax_ff <= miss_max_ff;
         out_lmin_ff <= lat_min_ff;
         out_lmax_ff <= lat_max_ff;
         out_emin_ff <= exe_min_ff;
         out_emax_ff <= exe_max_ff;
         out_err_ff  <= err_ff;
         out_rv_ff   <= rv_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_exec_time_us      = out_ex_ff;
   assign rsp_latency_us        = out_lat_ff;
   assign rsp_missed_now        = out_mnow_ff;
   assign rsp_missed_total      = out_mtot_ff;
   assign rsp_max_single_missed = out_mmax_ff;
   assign rsp_latency_min       = out_lmin_ff;
   assign rsp_latency_max       = out_lmax_ff;
   assign rsp_exec_min          = out_emin_ff;
   assign rsp_exec_max          = out_emax_ff;
   assign rsp_error_code        = out_err_ff;
   assign rsp_read_value        = out_rv_ff;

   // Status to the sequencer
   always_comb begin
      sts.skip      = cfg.run_more & more_ff;
      sts.aperiodic = cfg.aperiodic;
      sts.p_zero    = cfg.period == 32'd0;
      sts.end_gt_nd = end_ff > nd_ff;
      sts.div_done  = div_done;
      sts.lat_hist  = cfg.measure & ~lat_neg & lat_in_hist;
      sts.clr_last  = clr_ff == HIST_AW'(HIST_BINS - 1);
      sts.out_free  = ~rsp_valid_ff | ~rsp_stall;
   end

   // Result register fills on load
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result not presented after load");

   // Histogram increment follows its own read, issued in the cycle before
   a_hist_rmw: assert property (@(posedge clock) disable iff (reset)
      cmd.hist_wr |-> $past(cmd.lat_upd))
      else $error("histogram write without matching read");

   // Clearing pass shares the memory with nothing else
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> !(cmd.hist_wr || cmd.bin_rd || cmd.lat_upd || cmd.capture))
      else $error("memory access during clearing pass");

   // Divider is never restarted mid-division
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule

`default_nettype wire
